@@ design/msre_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the multi-sensor register emulator.
package msre_pkg;

  // Function codes of an input item
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // Access checks
  localparam logic [7:0] ADDR_MAX   = 8'h7F;
  localparam logic [7:0] REG_MAX    = 8'd5;
  localparam logic [7:0] ACCESS_LEN = 8'd2;

  // Register map of one emulated sensor
  localparam int unsigned NUM_REGS  = 6;
  localparam logic [2:0] R_CONFIG   = 3'd0;
  localparam logic [2:0] R_SHUNT    = 3'd1;
  localparam logic [2:0] R_BUS      = 3'd2;
  localparam logic [2:0] R_POWER    = 3'd3;
  localparam logic [2:0] R_CURRENT  = 3'd4;
  localparam logic [2:0] R_CAL      = 3'd5;

  localparam logic [15:0] CONFIG_DEFAULT = 16'h399F;
  localparam logic [15:0] CAL_DEFAULT    = 16'd4096;

  // Waveform periods and offsets
  localparam logic [7:0]  PERIOD_CURRENT = 8'd60;
  localparam logic [7:0]  PERIOD_SHUNT   = 8'd30;
  localparam logic [7:0]  PERIOD_BUS     = 8'd120;
  localparam logic [7:0]  PERIOD_POWER   = 8'd80;
  localparam logic [15:0] CURRENT_BASE   = 16'd220;
  localparam logic [15:0] SHUNT_BASE     = 16'd80;
  localparam logic [15:0] BUS_BASE       = 16'd3000;
  localparam logic [15:0] POWER_BASE     = 16'd350;
  localparam int unsigned BUS_SHIFT      = 3;

  // Residue unit: three pipeline steps, 7-bit residues
  localparam int unsigned MOD_CYCLES = 3;
  localparam int unsigned MCW        = $clog2(MOD_CYCLES);
  localparam int unsigned RES_W      = 7;
  localparam logic [3:0]  RES15      = 4'd15;
  localparam logic [3:0]  RES5       = 4'd5;
  localparam logic [3:0]  INV5_MOD16 = 4'd13;

  // Last register counter value of the measurement writes per slot in a tick (four registers)
  localparam logic [2:0] MEAS_LAST = 3'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic clr_slot;
    logic inc_slot;
    logic rd_addr;
    logic claim;
    logic clr_reg;
    logic wr_init;
    logic acc_rd;
    logic acc_wr;
    logic tick_load;
    logic mod_step;
    logic wr_meas;
    logic res_ok_set;
    logic res_data_cap;
    logic push;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic item_bad;
    logic is_tick;
    logic is_read;
    logic table_empty;
    logic table_full;
    logic slot_last;
    logic match;
    logic reg_last;
    logic meas_last;
    logic mod_last;
    logic out_free;
  } status_t;

endpackage

@@ design/msre_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
module msre_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/msre_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine: sequences slot search, claim, access and tick sweep.
module msre_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  msre_pkg::status_t status_i,
  output msre_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_CHECK    = 4'd1;
  localparam logic [3:0] ST_SRCH_RD  = 4'd2;
  localparam logic [3:0] ST_SRCH_CMP = 4'd3;
  localparam logic [3:0] ST_CLAIM    = 4'd4;
  localparam logic [3:0] ST_INIT     = 4'd5;
  localparam logic [3:0] ST_ACC      = 4'd6;
  localparam logic [3:0] ST_ACC_WAIT = 4'd7;
  localparam logic [3:0] ST_TICK_RD  = 4'd8;
  localparam logic [3:0] ST_TICK_LD  = 4'd9;
  localparam logic [3:0] ST_TICK_MOD = 4'd10;
  localparam logic [3:0] ST_TICK_WR  = 4'd11;
  localparam logic [3:0] ST_RESP     = 4'd12;

  logic [3:0] state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.item_bad) begin
          state_d = ST_RESP;
        end else if (status_i.is_tick) begin
          if (status_i.table_empty) begin
            cmd_o.res_ok_set = 1'b1;
            state_d          = ST_RESP;
          end else begin
            cmd_o.clr_slot = 1'b1;
            state_d        = ST_TICK_RD;
          end
        end else if (status_i.table_empty) begin
          state_d = ST_CLAIM;
        end else begin
          cmd_o.clr_slot = 1'b1;
          state_d        = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        cmd_o.rd_addr = 1'b1;
        state_d       = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        if (status_i.match) begin
          state_d = ST_ACC;
        end else if (!status_i.slot_last) begin
          cmd_o.inc_slot = 1'b1;
          state_d        = ST_SRCH_RD;
        end else if (status_i.table_full) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_CLAIM;
        end
      end
      ST_CLAIM: begin
        cmd_o.claim   = 1'b1;
        cmd_o.clr_reg = 1'b1;
        state_d       = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.wr_init = 1'b1;
        if (status_i.reg_last) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (status_i.is_read) begin
          cmd_o.acc_rd = 1'b1;
          state_d      = ST_ACC_WAIT;
        end else begin
          cmd_o.acc_wr     = 1'b1;
          cmd_o.res_ok_set = 1'b1;
          state_d          = ST_RESP;
        end
      end
      ST_ACC_WAIT: begin
        cmd_o.res_data_cap = 1'b1;
        cmd_o.res_ok_set   = 1'b1;
        state_d            = ST_RESP;
      end
      ST_TICK_RD: begin
        cmd_o.rd_addr = 1'b1;
        state_d       = ST_TICK_LD;
      end
      ST_TICK_LD: begin
        cmd_o.tick_load = 1'b1;
        state_d         = ST_TICK_MOD;
      end
      ST_TICK_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) begin
          cmd_o.clr_reg = 1'b1;
          state_d       = ST_TICK_WR;
        end
      end
      ST_TICK_WR: begin
        cmd_o.wr_meas = 1'b1;
        if (status_i.meas_last) begin
          if (status_i.slot_last) begin
            cmd_o.res_ok_set = 1'b1;
            state_d          = ST_RESP;
          end else begin
            cmd_o.inc_slot = 1'b1;
            state_d        = ST_TICK_RD;
          end
        end
      end
      ST_RESP: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A slot is claimed only while the table has room
  a_claim_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.claim |-> !status_i.table_full)
    else $error("slot claimed with a full table");

  // An accepted item always goes to the check step
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i) |=> (state_q == ST_CHECK))
    else $error("accepted item did not reach the check step");

  // The result waits until the output register is free
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && !status_i.out_free) |=> (state_q == ST_RESP))
    else $error("result left before the output register was free");

endmodule

@@ design/msre_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: item latch, slot tables, residue unit and output register.
module msre_datapath #(
  parameter int unsigned MAX_SLOTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        func_i,
  input  logic [7:0]        bus_address_i,
  input  logic [7:0]        reg_index_i,
  input  logic [7:0]        access_length_i,
  input  logic [15:0]       write_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              ok_o,
  output logic [15:0]       read_data_o,
  input  msre_pkg::cmd_t    cmd_i,
  output msre_pkg::status_t status_o
);

  localparam int unsigned SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned RD  = MAX_SLOTS * msre_pkg::NUM_REGS;
  localparam int unsigned RAW = $clog2(RD);
  localparam int unsigned RW  = msre_pkg::RES_W;

  // Latched item
  logic [1:0]  func_q;
  logic [7:0]  addr_q, reg_q, len_q;
  logic [15:0] wdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q  <= func_i;
      addr_q  <= bus_address_i;
      reg_q   <= reg_index_i;
      len_q   <= access_length_i;
      wdata_q <= write_data_i;
    end
  end

  // Slot index and fill count; slots are claimed in order and never freed
  logic [SW-1:0] slot_q;
  logic [CW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.claim) begin
        slot_q  <= count_q[SW-1:0];
        count_q <= count_q + CW'(1);
      end else if (cmd_i.clr_slot) begin
        slot_q <= '0;
      end else if (cmd_i.inc_slot) begin
        slot_q <= slot_q + SW'(1);
      end
    end
  end

  // Register counter for setup and measurement writes
  logic [2:0] regc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regc_q <= '0;
    end else if (cmd_i.clr_reg) begin
      regc_q <= '0;
    end else if (cmd_i.wr_init || cmd_i.wr_meas) begin
      regc_q <= regc_q + 3'd1;
    end
  end

  // Slot address and tick tables
  logic [6:0]  addr_rd;
  logic [31:0] tick_rd, tick_next;

  assign tick_next = tick_rd + 32'd1;

  msre_ram #(.WIDTH(7), .DEPTH(MAX_SLOTS)) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.claim),
    .waddr_i (count_q[SW-1:0]),
    .wdata_i (addr_q[6:0]),
    .re_i    (cmd_i.rd_addr),
    .raddr_i (slot_q),
    .rdata_o (addr_rd)
  );

  msre_ram #(.WIDTH(32), .DEPTH(MAX_SLOTS)) u_tick_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.claim || cmd_i.tick_load),
    .waddr_i (cmd_i.claim ? count_q[SW-1:0] : slot_q),
    .wdata_i (cmd_i.claim ? 32'd0 : tick_next),
    .re_i    (cmd_i.rd_addr),
    .raddr_i (slot_q),
    .rdata_o (tick_rd)
  );

  // Residue unit: 16 is 1 mod 15 and mod 5, so the nibble sum keeps those residues;
  // the low bits then pick the residue mod 60, 120, 80 or 30. One stage per step.
  function automatic logic [6:0] nib_sum(input logic [31:0] x);
    logic [4:0] p0, p1, p2, p3;
    p0 = {1'b0, x[3:0]} + {1'b0, x[7:4]};
    p1 = {1'b0, x[11:8]} + {1'b0, x[15:12]};
    p2 = {1'b0, x[19:16]} + {1'b0, x[23:20]};
    p3 = {1'b0, x[27:24]} + {1'b0, x[31:28]};
    return ({2'd0, p0} + {2'd0, p1}) + ({2'd0, p2} + {2'd0, p3});
  endfunction

  // Residue mod 15 of a nibble sum (at most 120)
  function automatic logic [3:0] fold15(input logic [6:0] s);
    logic [4:0] f;
    f = {2'd0, s[6:4]} + {1'b0, s[3:0]};
    if (f >= {1'b0, msre_pkg::RES15}) begin
      f = f - {1'b0, msre_pkg::RES15};
    end
    return f[3:0];
  endfunction

  // Residue mod 5 of a residue mod 15
  function automatic logic [2:0] mod5(input logic [3:0] r);
    logic [3:0] v;
    v = r;
    if (v >= 4'd10) begin
      v = v - 4'd10;
    end else if (v >= msre_pkg::RES5) begin
      v = v - msre_pkg::RES5;
    end
    return v[2:0];
  endfunction

  // r + k * step
  function automatic logic [RW-1:0] join_res(input logic [3:0] r, input logic [3:0] k,
                                             input logic [3:0] step);
    logic [7:0] v;
    v = {4'd0, r} + {4'd0, k} * {4'd0, step};
    return v[RW-1:0];
  endfunction

  logic [31:0]              x1_q, x2_q;
  logic [6:0]               sum1_q, sum2_q;
  logic [3:0]               r15a_q, r15b_q;
  logic [2:0]               r5_q;
  logic [RW-1:0]            r60_q, r30_q, r120_q, r80_q;
  logic [1:0]               k60;
  logic [2:0]               k120;
  logic [3:0]               d80, k80;
  logic [msre_pkg::MCW-1:0] modc_q;

  // Multiples of the coarse residue that match the low bits
  assign k60  = r15a_q[1:0] - x1_q[1:0];
  assign k120 = r15a_q[2:0] - x1_q[2:0];
  assign d80  = x1_q[3:0] - {1'b0, r5_q};
  assign k80  = d80 * msre_pkg::INV5_MOD16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modc_q <= '0;
    end else if (cmd_i.tick_load) begin
      modc_q <= '0;
    end else if (cmd_i.mod_step) begin
      modc_q <= modc_q + msre_pkg::MCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_load) begin
      x1_q <= tick_next + {25'd0, addr_rd};
      x2_q <= tick_next + {26'd0, addr_rd[6:1]};
    end else if (cmd_i.mod_step) begin
      sum1_q <= nib_sum(x1_q);
      sum2_q <= nib_sum(x2_q);
      r15a_q <= fold15(sum1_q);
      r15b_q <= fold15(sum2_q);
      r5_q   <= mod5(fold15(sum1_q));
      r60_q  <= join_res(r15a_q, {2'd0, k60}, msre_pkg::RES15);
      r120_q <= join_res(r15a_q, {1'b0, k120}, msre_pkg::RES15);
      r80_q  <= join_res({1'b0, r5_q}, k80, msre_pkg::RES5);
      r30_q  <= join_res(r15b_q, {3'd0, r15b_q[0] ^ x2_q[0]}, msre_pkg::RES15);
    end
  end

  // Measurement value and target register for the current write
  logic [15:0] bus_sum, meas_val;
  logic [2:0]  meas_reg;

  assign bus_sum = msre_pkg::BUS_BASE + {{(16-RW){1'b0}}, r120_q};

  always_comb begin
    case (regc_q)
      3'd0: begin
        meas_reg = msre_pkg::R_CURRENT;
        meas_val = msre_pkg::CURRENT_BASE + {{(16-RW){1'b0}}, r60_q};
      end
      3'd1: begin
        meas_reg = msre_pkg::R_SHUNT;
        meas_val = msre_pkg::SHUNT_BASE + {{(16-RW){1'b0}}, r30_q};
      end
      3'd2: begin
        meas_reg = msre_pkg::R_BUS;
        meas_val = bus_sum << msre_pkg::BUS_SHIFT;
      end
      default: begin
        meas_reg = msre_pkg::R_POWER;
        meas_val = msre_pkg::POWER_BASE + {{(16-RW){1'b0}}, r80_q};
      end
    endcase
  end

  // Setup value of a freshly claimed slot
  logic [15:0] init_val;

  always_comb begin
    case (regc_q)
      msre_pkg::R_CONFIG: init_val = msre_pkg::CONFIG_DEFAULT;
      msre_pkg::R_CAL:    init_val = msre_pkg::CAL_DEFAULT;
      default:            init_val = 16'd0;
    endcase
  end

  // Register table
  logic [2:0]     reg_sel;
  logic [RAW-1:0] reg_addr;
  logic [15:0]    reg_wdata, reg_rd;
  logic           reg_we;

  assign reg_sel   = cmd_i.wr_init ? regc_q : (cmd_i.wr_meas ? meas_reg : reg_q[2:0]);
  assign reg_addr  = RAW'(slot_q) * RAW'(msre_pkg::NUM_REGS) + RAW'(reg_sel);
  assign reg_we    = cmd_i.wr_init || cmd_i.acc_wr || cmd_i.wr_meas;
  assign reg_wdata = cmd_i.wr_init ? init_val : (cmd_i.wr_meas ? meas_val : wdata_q);

  msre_ram #(.WIDTH(16), .DEPTH(RD)) u_reg_ram (
    .clk_i   (clk_i),
    .we_i    (reg_we),
    .waddr_i (reg_addr),
    .wdata_i (reg_wdata),
    .re_i    (cmd_i.acc_rd),
    .raddr_i (reg_addr),
    .rdata_o (reg_rd)
  );

  // Pending result
  logic        res_ok_q;
  logic [15:0] res_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      res_ok_q   <= 1'b0;
      res_data_q <= '0;
    end else begin
      if (cmd_i.res_ok_set) begin
        res_ok_q <= 1'b1;
      end
      if (cmd_i.res_data_cap) begin
        res_data_q <= reg_rd;
      end
    end
  end

  // Output register; holds a result until its transfer
  logic        out_valid_q, ok_q;
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      ok_q    <= res_ok_q;
      rdata_q <= res_data_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign read_data_o = rdata_q;

  // Status to the controller
  always_comb begin
    status_o             = '0;
    status_o.is_tick     = (func_q == msre_pkg::FUNC_TICK);
    status_o.is_read     = (func_q == msre_pkg::FUNC_READ);
    status_o.item_bad    = (func_q != msre_pkg::FUNC_READ) &&
                           (func_q != msre_pkg::FUNC_WRITE) &&
                           (func_q != msre_pkg::FUNC_TICK);
    if (func_q != msre_pkg::FUNC_TICK &&
        (len_q != msre_pkg::ACCESS_LEN || reg_q > msre_pkg::REG_MAX ||
         addr_q > msre_pkg::ADDR_MAX)) begin
      status_o.item_bad = 1'b1;
    end
    status_o.table_empty = (count_q == '0);
    status_o.table_full  = (count_q == CW'(MAX_SLOTS));
    status_o.slot_last   = (CW'(slot_q) == count_q - CW'(1));
    status_o.match       = (addr_rd == addr_q[6:0]);
    status_o.reg_last    = (regc_q == 3'(msre_pkg::NUM_REGS - 1));
    status_o.meas_last   = (regc_q == msre_pkg::MEAS_LAST);
    status_o.mod_last    = (modc_q == msre_pkg::MCW'(msre_pkg::MOD_CYCLES - 1));
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

  // Fill count stays within the table
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_SLOTS))
    else $error("fill count beyond table size");

  // A result is loaded only into a free output register
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a pending output");

  // At most one source writes the register table in a cycle
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.wr_init, cmd_i.acc_wr, cmd_i.wr_meas}))
    else $error("register table written from two sources");

endmodule

@@ design/multi_sensor_register_emulator_unit.sv @@
`timescale 1ns / 1ps
// A write or read searches the claimed slots in order; when no slot matches and the table has room,
// a slot is claimed first (six setup writes through the single register table write port); items
// with a bad field are answered without a search, and a full table turns an access away after it.
// Tick: each active slot gets three residue steps, then four register writes.
// One item in flight; the next is taken while a result waits.
// Reset clears the fill count and handshake state; no memory clearing pass is needed.
module multi_sensor_register_emulator_unit #(
  parameter int unsigned MAX_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  bus_address_i,
  input  logic [7:0]  reg_index_i,
  input  logic [7:0]  access_length_i,
  input  logic [15:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [15:0] read_data_o
);

  msre_pkg::cmd_t    cmd;
  msre_pkg::status_t status;

  // Controller
  msre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath
  msre_datapath #(.MAX_SLOTS(MAX_SLOTS)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .func_i          (func_i),
    .bus_address_i   (bus_address_i),
    .reg_index_i     (reg_index_i),
    .access_length_i (access_length_i),
    .write_data_i    (write_data_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .ok_o            (ok_o),
    .read_data_o     (read_data_o),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule
